// File: sv/sha256s_pkg.sv
// shared types, constants and functions for the streaming sha-256 hasher
// depends on nothing
package sha256s_pkg;

    localparam logic [31:0] H_INIT [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam int LEN_POS = 56;

    // one full block handed from the packer to the compressor
    typedef struct packed {
        logic [511:0] words;   // word 0 in the top bits
        logic         final_blk;
    } blk_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// File: sv/sha256s_front.sv
// byte packer: builds 64-byte blocks, appends padding and length
// depends on sha256s_pkg
module sha256s_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid,
    output logic               ready,
    input  logic               kind,
    input  logic [7:0]         data_byte,
    output logic               blk_valid,
    input  logic               blk_ready,
    output sha256s_pkg::blk_t  blk
);

    localparam logic [1:0] S_FILL  = 2'd0;
    localparam logic [1:0] S_SEND  = 2'd1;
    localparam logic [1:0] S_LEN   = 2'd2;

    logic [1:0]   state_reg, state_next;
    logic [511:0] buf_reg, buf_next;
    logic [5:0]   pos_reg, pos_next;
    logic [63:0]  len_reg, len_next;
    logic         fin_reg, fin_next;
    logic         pend_reg, pend_next;   // a full block waits for the queue
    logic         take;
    logic [8:0]   bit_ofs;

    assign ready     = (state_reg == S_FILL) && !pend_reg;
    assign take      = valid && ready;
    assign blk_valid = pend_reg;
    assign blk.words = buf_reg;
    assign blk.final_blk = fin_reg;
    assign bit_ofs   = 9'(9'd504 - {pos_reg, 3'b000});

    always_comb
    begin
        state_next = state_reg;
        buf_next   = buf_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        fin_next   = fin_reg;
        pend_next  = pend_reg;
        if (pend_reg && blk_ready)
        begin
            pend_next = 1'b0;
            case (state_reg)
                S_SEND:
                begin
                    // tail overflowed: second block of zeros plus length
                    buf_next   = {448'd0, len_reg};
                    fin_next   = 1'b1;
                    pend_next  = 1'b1;
                    state_next = S_LEN;
                end
                S_LEN:
                begin
                    state_next = S_FILL;
                    len_next   = 64'd0;
                    fin_next   = 1'b0;
                end
                default: ;
            endcase
        end
        if (take)
        begin
            if (!kind)
            begin
                buf_next[bit_ofs +: 8] = data_byte;
                len_next = len_reg + 64'd8;
                pos_next = pos_reg + 6'd1;
                fin_next = 1'b0;
                if (pos_reg == 6'd63)
                    pend_next = 1'b1;
            end
            else
            begin
                buf_next[bit_ofs +: 8] = 8'h80;
                for (int i = 0; i < 64; i++)
                    if (6'(i) > pos_reg)
                        buf_next[504 - 8 * i +: 8] = 8'h00;
                pos_next  = 6'd0;
                pend_next = 1'b1;
                if (pos_reg >= 6'(sha256s_pkg::LEN_POS))
                begin
                    fin_next   = 1'b0;
                    state_next = S_SEND;
                end
                else
                begin
                    buf_next[63:0] = len_reg;
                    fin_next   = 1'b1;
                    state_next = S_LEN;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_FILL;
            pos_reg   <= 6'd0;
            len_reg   <= 64'd0;
            fin_reg   <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            fin_reg   <= fin_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule

// File: sv/sha256s_queue.sv
// two-entry block queue between packer and compressor
// depends on sha256s_pkg
module sha256s_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sha256s_pkg::blk_t  in_blk,
    output logic               out_valid,
    input  logic               out_ready,
    output sha256s_pkg::blk_t  out_blk
);

    sha256s_pkg::blk_t mem_reg [0:1];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_blk   = mem_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= 2'(cnt_reg + {1'b0, push} - {1'b0, pop});
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= in_blk;
    end

endmodule

// File: sv/sha256s_core.sv
// compression engine: one round per cycle, rolling schedule window,
// digest words streamed out through an output register; depends on sha256s_pkg
module sha256s_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               blk_valid,
    output logic               blk_ready,
    input  sha256s_pkg::blk_t  blk,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        digest_word,
    output logic               last_word
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ROUND = 2'd1;
    localparam logic [1:0] S_ADD   = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]  state_reg;
    logic [5:0]  rnd_reg;
    logic [2:0]  wi_reg;
    logic        fin_reg;
    logic [31:0] h_reg [0:7];
    logic [31:0] v_reg [0:7];
    logic [31:0] w_reg [0:15];
    logic        ov_reg;
    logic [31:0] dw_reg;
    logic        lw_reg;

    logic [31:0] wr, s0, s1, t1, t2, ss0, ss1, ch, maj;

    assign blk_ready   = state_reg == S_IDLE;
    assign out_valid   = ov_reg;
    assign digest_word = dw_reg;
    assign last_word   = lw_reg;

    // window shifts each round so w_reg[0] is always the current word
    always_comb
    begin
        s0 = sha256s_pkg::rotr(w_reg[1], 7) ^ sha256s_pkg::rotr(w_reg[1], 18)
            ^ (w_reg[1] >> 3);
        s1 = sha256s_pkg::rotr(w_reg[14], 17) ^ sha256s_pkg::rotr(w_reg[14], 19)
            ^ (w_reg[14] >> 10);
        wr  = w_reg[0];
        ss1 = sha256s_pkg::rotr(v_reg[4], 6) ^ sha256s_pkg::rotr(v_reg[4], 11)
            ^ sha256s_pkg::rotr(v_reg[4], 25);
        ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        ss0 = sha256s_pkg::rotr(v_reg[0], 2) ^ sha256s_pkg::rotr(v_reg[0], 13)
            ^ sha256s_pkg::rotr(v_reg[0], 22);
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1  = v_reg[7] + ss1 + ch + sha256s_pkg::ROUND_K[rnd_reg] + wr;
        t2  = ss0 + maj;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rnd_reg   <= 6'd0;
            wi_reg    <= 3'd0;
            fin_reg   <= 1'b0;
            ov_reg    <= 1'b0;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= sha256s_pkg::H_INIT[i];
        end
        else
        begin
            if (ov_reg && out_ready)
                ov_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (blk_valid)
                    begin
                        fin_reg   <= blk.final_blk;
                        rnd_reg   <= 6'd0;
                        state_reg <= S_ROUND;
                    end
                S_ROUND:
                begin
                    rnd_reg <= rnd_reg + 6'd1;
                    if (rnd_reg == 6'd63)
                        state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    wi_reg    <= 3'd0;
                    state_reg <= fin_reg ? S_EMIT : S_IDLE;
                end
                S_EMIT:
                    if (!ov_reg || out_ready)
                    begin
                        ov_reg <= 1'b1;
                        wi_reg <= wi_reg + 3'd1;
                        if (wi_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                                h_reg[i] <= sha256s_pkg::H_INIT[i];
                            state_reg <= S_IDLE;
                        end
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && blk_valid)
        begin
            for (int i = 0; i < 16; i++)
                w_reg[i] <= blk.words[511 - 32 * i -: 32];
            for (int i = 0; i < 8; i++)
                v_reg[i] <= h_reg[i];
        end
        else if (state_reg == S_ROUND)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= s1 + w_reg[9] + s0 + w_reg[0];
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        if (state_reg == S_EMIT && (!ov_reg || out_ready))
        begin
            dw_reg <= h_reg[wi_reg];
            lw_reg <= wi_reg == 3'd7;
        end
    end

endmodule

// File: sv/sha256_stream_hasher_unit.sv
// streaming sha-256 hasher: byte packer, block queue, compression engine
// a block compresses in a load step, one round per cycle, then an add step;
// bytes are taken one per cycle while no full block waits for the queue, so
// throughput is bounded by the compressor
// S_EMIT registers the digest words after the final add; one per cycle while out_ready
// reset: asynchronous active-low rst_n restores initial hash values and clears length
module sha256_stream_hasher_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic        last_word
);

    sha256s_pkg::blk_t f_blk, q_blk;
    logic f_valid, f_ready, q_valid, q_ready;

    sha256s_front u_front (
        .clk(clk), .rst_n(rst_n),
        .valid(in_valid), .ready(in_ready),
        .kind(kind), .data_byte(data_byte),
        .blk_valid(f_valid), .blk_ready(f_ready), .blk(f_blk)
    );

    sha256s_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(f_valid), .in_ready(f_ready), .in_blk(f_blk),
        .out_valid(q_valid), .out_ready(q_ready), .out_blk(q_blk)
    );

    sha256s_core u_core (
        .clk(clk), .rst_n(rst_n),
        .blk_valid(q_valid), .blk_ready(q_ready), .blk(q_blk),
        .out_valid(out_valid), .out_ready(out_ready),
        .digest_word(digest_word), .last_word(last_word)
    );

endmodule
